/* rtl/lfsc_pkg.sv */
// ----------------------------------------------------------------------------
// lfsc_pkg
// Types, codes and reset values shared by the line follow sensor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

	localparam int SAMPLE_W  = 8;
	localparam int AVG_SHIFT = 2;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 32;

	localparam logic [SAMPLE_W-1:0] AVG_RESET = 8'd128;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TURN_RIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_LEFT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_REARM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOLID       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SOLID_REARM = 3'd5;

	localparam logic [SAMPLE_W-1:0] TURN_RIGHT_RST  = 8'd112;
	localparam logic [SAMPLE_W-1:0] TURN_LEFT_RST   = 8'd143;
	localparam logic [SAMPLE_W-1:0] BLINK_RST       = 8'd102;
	localparam logic [SAMPLE_W-1:0] BLINK_REARM_RST = 8'd120;
	localparam logic [SAMPLE_W-1:0] SOLID_RST       = 8'd153;
	localparam logic [SAMPLE_W-1:0] SOLID_REARM_RST = 8'd135;

	// heading
	localparam logic [1:0] HEAD_STOPPED = 2'd0;
	localparam logic [1:0] HEAD_FORWARD = 2'd1;
	localparam logic [1:0] HEAD_LEFT    = 2'd2;
	localparam logic [1:0] HEAD_RIGHT   = 2'd3;

	// drive commands
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_RIGHT   = 3'd1;
	localparam logic [2:0] CMD_LEFT    = 3'd2;
	localparam logic [2:0] CMD_FORWARD = 3'd3;
	localparam logic [2:0] CMD_RAMP    = 3'd4;

	// stop kinds and magnet events
	localparam logic [1:0] STOP_NONE   = 2'd0;
	localparam logic [1:0] STOP_NOW    = 2'd1;
	localparam logic [1:0] STOP_RAMPED = 2'd2;

	localparam logic [1:0] EVT_NONE  = 2'd0;
	localparam logic [1:0] EVT_BLINK = 2'd1;
	localparam logic [1:0] EVT_SOLID = 2'd2;

	// packed so that stop_kind sits in the lowest bits
	typedef struct packed {
		logic [1:0]          heading;
		logic [SAMPLE_W-1:0] ir_average;
		logic [SAMPLE_W-1:0] hall_average;
		logic [2:0]          drive_command;
		logic [1:0]          magnet_event;
		logic [1:0]          stop_kind;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	function automatic logic [SAMPLE_W-1:0] ema_update(
		input logic [SAMPLE_W-1:0] avg,
		input logic [SAMPLE_W-1:0] sample
	);
		ema_update = avg - (avg >> AVG_SHIFT) + (sample >> AVG_SHIFT);
	endfunction

endpackage

`default_nettype wire

/* rtl/line_follow_sensor_controller.sv */
// ----------------------------------------------------------------------------
// line_follow_sensor_controller
// Sensor averaging, magnet event detection and steering heading machine.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one hall/IR sample pair per transaction; m_* returns exactly
//   one result per input transaction, in order. cfg_* writes one of the six
//   threshold registers; it is always ready and must only be used while idle.
//   An input transaction is captured in the input register (_s1). When the
//   output register is free or being taken, the averages, magnet checks and
//   heading step are evaluated from _s1 and written to the output register
//   together with the running state, which then presents the result on m_*.
//   One transaction per cycle is sustained while m_tready stays high; the
//   running state is updated once per item as it leaves the input register.
//   When m_tready is low the output register holds, the input register fills,
//   and s_tready drops until the output is taken.
//   Reset: averages 128, heading stopped, event flags clear, thresholds at
//   their default values, both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_sensor_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [lfsc_pkg::IN_DATA_W-1:0]   s_tdata,   // hall_sample, ir_sample
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [lfsc_pkg::OUT_DATA_W-1:0]       m_tdata,   // stop_kind, magnet_event,
	                                                         // drive_command, hall_average,
	                                                         // ir_average, heading, zeros
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lfsc_pkg::SAMPLE_W-1:0]    cfg_data
);

	logic [lfsc_pkg::SAMPLE_W-1:0] turn_right_q, turn_left_q;
	logic [lfsc_pkg::SAMPLE_W-1:0] blink_lvl_q, blink_rearm_q;
	logic [lfsc_pkg::SAMPLE_W-1:0] solid_lvl_q, solid_rearm_q;

	logic [lfsc_pkg::SAMPLE_W-1:0] hall_avg_q, ir_avg_q;
	logic                          blink_seen_q, solid_seen_q;
	logic [1:0]                    heading_q;

	logic                          valid_s1;
	logic [lfsc_pkg::SAMPLE_W-1:0] hall_s1, ir_s1;

	logic                          out_valid_q;
	lfsc_pkg::result_t             out_q;

	logic                          advance;
	logic                          take_in;

	lfsc_pkg::result_t             res;
	logic [lfsc_pkg::SAMPLE_W-1:0] hall_nxt, ir_nxt;
	logic                          blink_nxt, solid_nxt;
	logic [1:0]                    heading_nxt;
	logic [1:0]                    stop_on_event;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(lfsc_pkg::OUT_DATA_W - lfsc_pkg::RESULT_W){1'b0}}, out_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_right_q  <= lfsc_pkg::TURN_RIGHT_RST;
			turn_left_q   <= lfsc_pkg::TURN_LEFT_RST;
			blink_lvl_q   <= lfsc_pkg::BLINK_RST;
			blink_rearm_q <= lfsc_pkg::BLINK_REARM_RST;
			solid_lvl_q   <= lfsc_pkg::SOLID_RST;
			solid_rearm_q <= lfsc_pkg::SOLID_REARM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfsc_pkg::REG_TURN_RIGHT:  turn_right_q  <= cfg_data;
				lfsc_pkg::REG_TURN_LEFT:   turn_left_q   <= cfg_data;
				lfsc_pkg::REG_BLINK:       blink_lvl_q   <= cfg_data;
				lfsc_pkg::REG_BLINK_REARM: blink_rearm_q <= cfg_data;
				lfsc_pkg::REG_SOLID:       solid_lvl_q   <= cfg_data;
				lfsc_pkg::REG_SOLID_REARM: solid_rearm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one step of the model
	always_comb begin
		hall_nxt      = lfsc_pkg::ema_update(hall_avg_q, hall_s1);
		ir_nxt        = lfsc_pkg::ema_update(ir_avg_q, ir_s1);
		blink_nxt     = blink_seen_q;
		solid_nxt     = solid_seen_q;
		heading_nxt   = heading_q;
		stop_on_event = (heading_q == lfsc_pkg::HEAD_FORWARD) ?
			lfsc_pkg::STOP_RAMPED : lfsc_pkg::STOP_NOW;

		res               = '0;
		res.stop_kind     = lfsc_pkg::STOP_NONE;
		res.magnet_event  = lfsc_pkg::EVT_NONE;
		res.drive_command = lfsc_pkg::CMD_NONE;

		if (hall_nxt < blink_lvl_q && !blink_seen_q) begin
			res.stop_kind    = stop_on_event;
			res.magnet_event = lfsc_pkg::EVT_BLINK;
			blink_nxt        = 1'b1;
		end else if (hall_nxt > solid_lvl_q && !solid_seen_q) begin
			res.stop_kind    = stop_on_event;
			res.magnet_event = lfsc_pkg::EVT_SOLID;
			solid_nxt        = 1'b1;
		end
		if (hall_nxt > blink_rearm_q)
			blink_nxt = 1'b0;
		if (hall_nxt < solid_rearm_q)
			solid_nxt = 1'b0;

		if (ir_nxt < turn_right_q) begin
			if (heading_q != lfsc_pkg::HEAD_RIGHT) begin
				res.drive_command = lfsc_pkg::CMD_RIGHT;
				heading_nxt       = lfsc_pkg::HEAD_RIGHT;
			end
		end else if (ir_nxt > turn_left_q) begin
			if (heading_q != lfsc_pkg::HEAD_LEFT) begin
				res.drive_command = lfsc_pkg::CMD_LEFT;
				heading_nxt       = lfsc_pkg::HEAD_LEFT;
			end
		end else if (heading_q != lfsc_pkg::HEAD_FORWARD) begin
			res.drive_command = (heading_q == lfsc_pkg::HEAD_STOPPED) ?
				lfsc_pkg::CMD_RAMP : lfsc_pkg::CMD_FORWARD;
			heading_nxt       = lfsc_pkg::HEAD_FORWARD;
		end

		res.hall_average = hall_nxt;
		res.ir_average   = ir_nxt;
		res.heading      = heading_nxt;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			hall_s1 <= s_tdata[lfsc_pkg::SAMPLE_W-1:0];
			ir_s1   <= s_tdata[2*lfsc_pkg::SAMPLE_W-1:lfsc_pkg::SAMPLE_W];
		end
	end

	// running state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_avg_q   <= lfsc_pkg::AVG_RESET;
			ir_avg_q     <= lfsc_pkg::AVG_RESET;
			blink_seen_q <= 1'b0;
			solid_seen_q <= 1'b0;
			heading_q    <= lfsc_pkg::HEAD_STOPPED;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				hall_avg_q   <= hall_nxt;
				ir_avg_q     <= ir_nxt;
				blink_seen_q <= blink_nxt;
				solid_seen_q <= solid_nxt;
				heading_q    <= heading_nxt;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	// checks
	a_event_has_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_q.stop_kind == lfsc_pkg::STOP_NONE) ==
			(out_q.magnet_event == lfsc_pkg::EVT_NONE)))
		else $error("stop kind and magnet event disagree");

	a_right_cmd_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.drive_command == lfsc_pkg::CMD_RIGHT) |->
			(out_q.heading == lfsc_pkg::HEAD_RIGHT))
		else $error("right command without right heading");

	a_fwd_cmd_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.drive_command == lfsc_pkg::CMD_FORWARD ||
			out_q.drive_command == lfsc_pkg::CMD_RAMP)) |->
			(out_q.heading == lfsc_pkg::HEAD_FORWARD))
		else $error("forward command without forward heading");

	a_state_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (heading_q == out_q.heading && hall_avg_q == out_q.hall_average &&
			ir_avg_q == out_q.ir_average))
		else $error("running state differs from last result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire
